/* hdl/mrrd_pkg.sv */
package mrrd_pkg;

   localparam int unsigned MAX_REPORT_BYTES_DEF = 22;
   localparam int unsigned CMD_QUEUE_DEPTH = 2;
   localparam int unsigned RSP_QUEUE_DEPTH = 2;

   localparam logic [7:0] TYPE_STATUS       = 8'h20;
   localparam logic [7:0] TYPE_READ_DATA    = 8'h21;
   localparam logic [7:0] TYPE_WRITE_ACK    = 8'h22;
   localparam logic [7:0] TYPE_BUTTONS      = 8'h30;
   localparam logic [7:0] TYPE_BUTTONS_ACC  = 8'h31;
   localparam logic [7:0] TYPE_ACCEL_IR     = 8'h33;
   localparam logic [7:0] ALL_ONES_BYTE     = 8'hff;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic [7:0] rtype;
      logic       btn_hi;
      logic       btn_lo;
      logic       flags;
      logic       battery;
      logic       accel;
      logic [1:0] accel_idx;
      logic       ir_lo;
      logic [1:0] ir_idx;
      logic       spot0;
      logic       spot1;
   } cmd_type;

   typedef struct packed {
      logic [7:0] report_type;
      logic [10:0] buttons;
      logic [7:0] accel_x;
      logic [7:0] accel_y;
      logic [7:0] accel_z;
      logic [9:0] spot1_x;
      logic [9:0] spot1_y;
      logic [9:0] spot2_x;
      logic [9:0] spot2_y;
      logic [1:0] spots_found;
      logic [6:0] status_flags;
      logic [7:0] battery_level;
   } rsp_type;

endpackage

/* hdl/mrrd_fifo.sv */
module mrrd_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/mrrd_front.sv */
module mrrd_front import mrrd_pkg::*; #(
   parameter int unsigned MAX_REPORT_BYTES = MAX_REPORT_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_report_byte,
   input  logic       req_last_byte,
   input  logic       queue_full,
   output logic       cmd_push,
   output cmd_type    cmd
);

   localparam int unsigned PW = $clog2(MAX_REPORT_BYTES);
   localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_REPORT_BYTES - 1);

   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]    type_ff, type_in;
   logic          first;
   logic          has_btn, has_accel, is_status, is_ir;

   assign first     = (pos_ff == '0);
   assign is_status = (type_ff == TYPE_STATUS);
   assign is_ir     = (type_ff == TYPE_ACCEL_IR);
   assign has_accel = (type_ff == TYPE_BUTTONS_ACC) || is_ir;
   assign has_btn   = is_status || (type_ff == TYPE_READ_DATA) ||
                      (type_ff == TYPE_BUTTONS) || has_accel;
   assign cmd_push  = req_push && !queue_full;

   always_comb begin
      cmd.data      = req_report_byte;
      cmd.last      = req_last_byte;
      cmd.rtype     = first ? req_report_byte : type_ff;
      cmd.btn_hi    = has_btn && (pos_ff == PW'(1));
      cmd.btn_lo    = has_btn && (pos_ff == PW'(2));
      cmd.flags     = is_status && (pos_ff == PW'(2));
      cmd.battery   = is_status && (pos_ff == PW'(6));
      cmd.accel     = has_accel && ((pos_ff == PW'(3)) || (pos_ff == PW'(4)) ||
                                    (pos_ff == PW'(5)));
      cmd.accel_idx = {pos_ff == PW'(5), pos_ff == PW'(4)};
      cmd.ir_lo     = is_ir && ((pos_ff == PW'(6)) || (pos_ff == PW'(7)) ||
                                (pos_ff == PW'(9)) || (pos_ff == PW'(10)));
      cmd.ir_idx    = {(pos_ff == PW'(9)) || (pos_ff == PW'(10)),
                       (pos_ff == PW'(7)) || (pos_ff == PW'(10))};
      cmd.spot0     = is_ir && (pos_ff == PW'(8));
      cmd.spot1     = is_ir && (pos_ff == PW'(11));
   end

   always_comb begin
      pos_in  = pos_ff;
      type_in = type_ff;
      if (cmd_push) begin
         if (first) begin
            type_in = req_report_byte;
         end
         if (req_last_byte) begin
            pos_in = '0;
         end else if (pos_ff < POS_LIMIT) begin
            pos_in = pos_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         type_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         type_ff <= type_in;
      end
   end

endmodule

/* hdl/mrrd_back.sv */
module mrrd_back import mrrd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   input  logic    out_full,
   output logic    rsp_push,
   output rsp_type rsp
);

   logic [10:0] buttons_ff, buttons_in;
   logic [7:0]  accel_ff [3];
   logic [7:0]  accel_in [3];
   logic [7:0]  ir_lo_ff [4];
   logic [7:0]  ir_lo_in [4];
   logic [9:0]  spots_ff [4];
   logic [9:0]  spots_in [4];
   logic [1:0]  found_ff, found_in;
   logic [6:0]  flags_ff, flags_in;
   logic [7:0]  battery_ff, battery_in;
   logic        go;
   logic [7:0]  b;

   assign go       = cmd_valid && !out_full;
   assign cmd_pop  = go;
   assign rsp_push = go && cmd.last;
   assign b        = cmd.data;

   always_comb begin
      buttons_in = buttons_ff;
      accel_in   = accel_ff;
      ir_lo_in   = ir_lo_ff;
      spots_in   = spots_ff;
      found_in   = found_ff;
      flags_in   = flags_ff;
      battery_in = battery_ff;
      if (go) begin
         if (cmd.btn_hi) begin
            buttons_in = (buttons_ff & 11'h06f) |
                         {b[1], b[0], b[2], b[3], 2'b00, b[4], 4'b0000};
         end
         if (cmd.btn_lo) begin
            buttons_in = (buttons_ff & 11'h790) |
                         {4'b0000, b[7], b[4], 1'b0, b[0], b[1], b[2], b[3]};
         end
         if (cmd.flags) begin
            flags_in = b[7:1];
         end
         if (cmd.battery) begin
            battery_in = b;
         end
         if (cmd.accel) begin
            accel_in[cmd.accel_idx] = b;
         end
         if (cmd.ir_lo) begin
            ir_lo_in[cmd.ir_idx] = b;
         end
         if (cmd.spot0) begin
            spots_in[0] = {b[5:4], ir_lo_ff[0]};
            spots_in[1] = {b[7:6], ir_lo_ff[1]};
            found_in[0] = !((ir_lo_ff[0] == ALL_ONES_BYTE) &&
                            (ir_lo_ff[1] == ALL_ONES_BYTE) && (b == ALL_ONES_BYTE));
         end
         if (cmd.spot1) begin
            spots_in[2] = {b[5:4], ir_lo_ff[2]};
            spots_in[3] = {b[7:6], ir_lo_ff[3]};
            found_in[1] = !((ir_lo_ff[2] == ALL_ONES_BYTE) &&
                            (ir_lo_ff[3] == ALL_ONES_BYTE) && (b == ALL_ONES_BYTE));
         end
      end
   end

   always_comb begin
      rsp.report_type   = cmd.rtype;
      rsp.buttons       = buttons_in;
      rsp.accel_x       = accel_in[0];
      rsp.accel_y       = accel_in[1];
      rsp.accel_z       = accel_in[2];
      rsp.spot1_x       = spots_in[0];
      rsp.spot1_y       = spots_in[1];
      rsp.spot2_x       = spots_in[2];
      rsp.spot2_y       = spots_in[3];
      rsp.spots_found   = found_in;
      rsp.status_flags  = flags_in;
      rsp.battery_level = battery_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buttons_ff <= '0;
         accel_ff   <= '{default: '0};
         ir_lo_ff   <= '{default: '0};
         spots_ff   <= '{default: '0};
         found_ff   <= '0;
         flags_ff   <= '0;
         battery_ff <= '0;
      end else begin
         buttons_ff <= buttons_in;
         accel_ff   <= accel_in;
         ir_lo_ff   <= ir_lo_in;
         spots_ff   <= spots_in;
         found_ff   <= found_in;
         flags_ff   <= flags_in;
         battery_ff <= battery_in;
      end
   end

endmodule

/* hdl/motion_remote_report_decoder.sv */
// Motion-controller input report decoder.
// Input: one report byte per beat on req_report_byte, req_last_byte marking
//   the final byte; a beat is taken when req_push is high and req_full low.
// Output: one snapshot beat per report, at its last byte, shown while
//   rsp_empty is low and taken when rsp_pop is high.
// Throughput: one byte per clock, sustained while rsp_pop keeps up.
// Path: the last byte of a report is written into the command queue; the
//   back stage then runs the decode logic on it and writes the snapshot
//   into the result queue, from which it shows.
// A front stage tracks the byte position and report type and tags each byte;
//   a two-entry command queue feeds the back stage, which holds the decoded
//   fields and writes snapshots into a two-entry result queue.
// Reset: synchronous; clears position, type, all held fields and both queues.
// Stall: when rsp_pop stays low the result queue fills, the back stage halts,
//   the command queue fills and req_full rises; no beat is lost.
module motion_remote_report_decoder import mrrd_pkg::*; #(
   parameter int unsigned MAX_REPORT_BYTES = MAX_REPORT_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_report_byte,
   input  logic        req_last_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_report_type,
   output logic [10:0] rsp_buttons,
   output logic [7:0]  rsp_accel_x,
   output logic [7:0]  rsp_accel_y,
   output logic [7:0]  rsp_accel_z,
   output logic [9:0]  rsp_spot1_x,
   output logic [9:0]  rsp_spot1_y,
   output logic [9:0]  rsp_spot2_x,
   output logic [9:0]  rsp_spot2_y,
   output logic [1:0]  rsp_spots_found,
   output logic [6:0]  rsp_status_flags,
   output logic [7:0]  rsp_battery_level
);

   cmd_type cmd_tail, cmd_head;
   logic [$bits(cmd_type)-1:0] cmd_head_bits;
   logic    cmd_push, cmd_full, cmd_empty, cmd_pop;
   rsp_type rsp_tail, rsp_head;
   logic [$bits(rsp_type)-1:0] rsp_head_bits;
   logic    rsp_push, rsp_full;

   assign req_full = cmd_full;
   assign cmd_head = cmd_type'(cmd_head_bits);
   assign rsp_head = rsp_type'(rsp_head_bits);

   mrrd_front #(
      .MAX_REPORT_BYTES(MAX_REPORT_BYTES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_report_byte (req_report_byte),
      .req_last_byte   (req_last_byte),
      .queue_full      (cmd_full),
      .cmd_push        (cmd_push),
      .cmd             (cmd_tail)
   );

   mrrd_fifo #(
      .WIDTH($bits(cmd_type)),
      .DEPTH(CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_tail),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_head_bits),
      .empty     (cmd_empty)
   );

   mrrd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cmd_empty),
      .cmd       (cmd_head),
      .cmd_pop   (cmd_pop),
      .out_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_tail)
   );

   mrrd_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_tail),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head_bits),
      .empty     (rsp_empty)
   );

   assign rsp_report_type   = rsp_head.report_type;
   assign rsp_buttons       = rsp_head.buttons;
   assign rsp_accel_x       = rsp_head.accel_x;
   assign rsp_accel_y       = rsp_head.accel_y;
   assign rsp_accel_z       = rsp_head.accel_z;
   assign rsp_spot1_x       = rsp_head.spot1_x;
   assign rsp_spot1_y       = rsp_head.spot1_y;
   assign rsp_spot2_x       = rsp_head.spot2_x;
   assign rsp_spot2_y       = rsp_head.spot2_y;
   assign rsp_spots_found   = rsp_head.spots_found;
   assign rsp_status_flags  = rsp_head.status_flags;
   assign rsp_battery_level = rsp_head.battery_level;

endmodule

/* hdl/mrrd_checker.sv */
module mrrd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [7:0]  rsp_report_type,
   input logic [10:0] rsp_buttons,
   input logic [9:0]  rsp_spot1_x,
   input logic [9:0]  rsp_spot1_y,
   input logic [9:0]  rsp_spot2_x,
   input logic [9:0]  rsp_spot2_y,
   input logic [1:0]  rsp_spots_found
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not cleared by reset");

   a_full_after_push: assert property (@(posedge clock) disable iff (reset)
      $rose(req_full) |-> $past(req_push))
      else $error("req_full rose without a beat taken");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=>
         !rsp_empty && $stable(rsp_report_type) && $stable(rsp_buttons))
      else $error("stalled result changed");

   a_spot1_lost: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_spots_found[0] |->
         (rsp_spot1_x == 10'd0 && rsp_spot1_y == 10'd0) ||
         (rsp_spot1_x == 10'h3ff && rsp_spot1_y == 10'h3ff))
      else $error("first spot not found but coordinates decoded");

   a_spot2_lost: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_spots_found[1] |->
         (rsp_spot2_x == 10'd0 && rsp_spot2_y == 10'd0) ||
         (rsp_spot2_x == 10'h3ff && rsp_spot2_y == 10'h3ff))
      else $error("second spot not found but coordinates decoded");

endmodule

bind motion_remote_report_decoder mrrd_checker u_mrrd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_push        (req_push),
   .req_full        (req_full),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_report_type (rsp_report_type),
   .rsp_buttons     (rsp_buttons),
   .rsp_spot1_x     (rsp_spot1_x),
   .rsp_spot1_y     (rsp_spot1_y),
   .rsp_spot2_x     (rsp_spot2_x),
   .rsp_spot2_y     (rsp_spot2_y),
   .rsp_spots_found (rsp_spots_found)
);

/* dv/motion_remote_report_decoder_tb.sv */
module motion_remote_report_decoder_tb;
   import mrrd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned REPORT_BYTES = MAX_REPORT_BYTES_DEF;
   localparam int unsigned QUIET_LIMIT = 5000;
   localparam int unsigned BYTES_PER_PHASE = 400;
   localparam int unsigned FILL_ZERO = 0;
   localparam int unsigned FILL_ONES = 1;
   localparam int unsigned FILL_RANDOM = 2;
   localparam logic [7:0] KNOWN_TYPES [6] = '{TYPE_STATUS, TYPE_READ_DATA, TYPE_WRITE_ACK,
                                             TYPE_BUTTONS, TYPE_BUTTONS_ACC, TYPE_ACCEL_IR};

   class snapshot_scoreboard;
      bit [4:0]  position;
      bit [7:0]  cur_type;
      bit [10:0] buttons;
      bit [7:0]  accel [3];
      bit [7:0]  ir [6];
      bit [9:0]  spots [4];
      bit [1:0]  found;
      bit [6:0]  flags;
      bit [7:0]  battery;
      rsp_type   expected_snapshots [$];
      int unsigned errors;

      function void latch_spot(int unsigned k);
         spots[2*k]     = {ir[3*k+2][5:4], ir[3*k]};
         spots[2*k + 1] = {ir[3*k+2][7:6], ir[3*k+1]};
         found[k] = !(ir[3*k] == ALL_ONES_BYTE && ir[3*k+1] == ALL_ONES_BYTE &&
                      ir[3*k+2] == ALL_ONES_BYTE);
      endfunction

      function void note_byte(bit [7:0] b, bit last);
         bit has_buttons;
         bit has_accel;
         bit [4:0] pos;
         rsp_type snap;
         pos = position;
         if (pos == 0) begin
            cur_type = b;
         end else begin
            has_buttons = (cur_type == TYPE_STATUS || cur_type == TYPE_READ_DATA ||
                           cur_type == TYPE_BUTTONS || cur_type == TYPE_BUTTONS_ACC ||
                           cur_type == TYPE_ACCEL_IR);
            has_accel = (cur_type == TYPE_BUTTONS_ACC || cur_type == TYPE_ACCEL_IR);
            if (has_buttons && pos == 1) begin
               buttons &= 11'h06f;
               buttons[4]  = b[4];
               buttons[7]  = b[3];
               buttons[8]  = b[2];
               buttons[9]  = b[0];
               buttons[10] = b[1];
            end
            if (has_buttons && pos == 2) begin
               buttons &= 11'h790;
               buttons[0] = b[3];
               buttons[1] = b[2];
               buttons[2] = b[1];
               buttons[3] = b[0];
               buttons[5] = b[4];
               buttons[6] = b[7];
            end
            if (cur_type == TYPE_STATUS) begin
               if (pos == 2) flags = b[7:1];
               if (pos == 6) battery = b;
            end
            if (has_accel && pos >= 3 && pos <= 5) accel[pos - 3] = b;
            if (cur_type == TYPE_ACCEL_IR && pos >= 6 && pos <= 11) begin
               ir[pos - 6] = b;
               if (pos == 8) latch_spot(0);
               if (pos == 11) latch_spot(1);
            end
         end
         if (!last) begin
            if (pos < REPORT_BYTES - 1) position = pos + 5'd1;
            return;
         end
         position = 0;
         snap.report_type   = cur_type;
         snap.buttons       = buttons;
         snap.accel_x       = accel[0];
         snap.accel_y       = accel[1];
         snap.accel_z       = accel[2];
         snap.spot1_x       = spots[0];
         snap.spot1_y       = spots[1];
         snap.spot2_x       = spots[2];
         snap.spot2_y       = spots[3];
         snap.spots_found   = found;
         snap.status_flags  = flags;
         snap.battery_level = battery;
         expected_snapshots.push_back(snap);
      endfunction

      function void compare(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_snapshot(rsp_type got);
         rsp_type want;
         if (expected_snapshots.size() == 0) begin
            $display("%0t: snapshot with type %0d expected none got one", $time,
                     got.report_type);
            errors++;
            return;
         end
         want = expected_snapshots.pop_front();
         compare("report_type", want.report_type, got.report_type);
         compare("buttons", want.buttons, got.buttons);
         compare("accel_x", want.accel_x, got.accel_x);
         compare("accel_y", want.accel_y, got.accel_y);
         compare("accel_z", want.accel_z, got.accel_z);
         compare("spot1_x", want.spot1_x, got.spot1_x);
         compare("spot1_y", want.spot1_y, got.spot1_y);
         compare("spot2_x", want.spot2_x, got.spot2_x);
         compare("spot2_y", want.spot2_y, got.spot2_y);
         compare("spots_found", want.spots_found, got.spots_found);
         compare("status_flags", want.status_flags, got.status_flags);
         compare("battery_level", want.battery_level, got.battery_level);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_report_byte;
   logic        req_last_byte;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [7:0]  rsp_report_type;
   logic [10:0] rsp_buttons;
   logic [7:0]  rsp_accel_x;
   logic [7:0]  rsp_accel_y;
   logic [7:0]  rsp_accel_z;
   logic [9:0]  rsp_spot1_x;
   logic [9:0]  rsp_spot1_y;
   logic [9:0]  rsp_spot2_x;
   logic [9:0]  rsp_spot2_y;
   logic [1:0]  rsp_spots_found;
   logic [6:0]  rsp_status_flags;
   logic [7:0]  rsp_battery_level;

   snapshot_scoreboard sb = new();
   rsp_type     seen;
   int unsigned quiet_cycles = 0;
   int unsigned bytes_sent = 0;
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   bit          took_any;

   motion_remote_report_decoder dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_report_byte   (req_report_byte),
      .req_last_byte     (req_last_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_report_type   (rsp_report_type),
      .rsp_buttons       (rsp_buttons),
      .rsp_accel_x       (rsp_accel_x),
      .rsp_accel_y       (rsp_accel_y),
      .rsp_accel_z       (rsp_accel_z),
      .rsp_spot1_x       (rsp_spot1_x),
      .rsp_spot1_y       (rsp_spot1_y),
      .rsp_spot2_x       (rsp_spot2_x),
      .rsp_spot2_y       (rsp_spot2_y),
      .rsp_spots_found   (rsp_spots_found),
      .rsp_status_flags  (rsp_status_flags),
      .rsp_battery_level (rsp_battery_level)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         took_any = 1'b0;
         if (!rsp_empty && rsp_pop) begin
            seen.report_type   = rsp_report_type;
            seen.buttons       = rsp_buttons;
            seen.accel_x       = rsp_accel_x;
            seen.accel_y       = rsp_accel_y;
            seen.accel_z       = rsp_accel_z;
            seen.spot1_x       = rsp_spot1_x;
            seen.spot1_y       = rsp_spot1_y;
            seen.spot2_x       = rsp_spot2_x;
            seen.spot2_y       = rsp_spot2_y;
            seen.spots_found   = rsp_spots_found;
            seen.status_flags  = rsp_status_flags;
            seen.battery_level = rsp_battery_level;
            sb.check_snapshot(seen);
            took_any = 1'b1;
         end
         if (req_push && !req_full) begin
            sb.note_byte(req_report_byte, req_last_byte);
            took_any = 1'b1;
         end
         quiet_cycles = took_any ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push        <= 1'b1;
      req_report_byte <= b;
      req_last_byte   <= last;
      do @(posedge clock); while (req_full);
      bytes_sent++;
   endtask

   task automatic send_report(input logic [7:0] rtype, input int unsigned len,
                              input int unsigned fill);
      logic [7:0] b;
      bit miss1;
      bit miss2;
      miss1 = ($urandom_range(0, 3) == 0);
      miss2 = ($urandom_range(0, 3) == 0);
      send_byte(rtype, len == 1);
      for (int unsigned i = 1; i < len; i++) begin
         case (fill)
            FILL_ZERO: b = 8'h00;
            FILL_ONES: b = ALL_ONES_BYTE;
            default: b = 8'($urandom_range(0, 255));
         endcase
         if (fill == FILL_RANDOM && ((miss1 && i >= 6 && i <= 8) ||
                                     (miss2 && i >= 9 && i <= 11)))
            b = ALL_ONES_BYTE;
         send_byte(b, i == len - 1);
      end
   endtask

   task automatic send_random_report();
      logic [7:0] rtype;
      int unsigned len;
      int unsigned pick;
      if ($urandom_range(0, 99) < 75) rtype = KNOWN_TYPES[$urandom_range(0, 5)];
      else rtype = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 60) len = $urandom_range(12, REPORT_BYTES);
      else if (pick < 85) len = $urandom_range(1, 11);
      else len = $urandom_range(REPORT_BYTES + 1, REPORT_BYTES + 8);
      send_report(rtype, len, FILL_RANDOM);
   endtask

   initial begin
      reset           = 1'b1;
      req_push        = 1'b0;
      req_report_byte = 8'h00;
      req_last_byte   = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_report(TYPE_BUTTONS, 1, FILL_RANDOM);
      send_report(TYPE_ACCEL_IR, 12, FILL_ZERO);
      send_report(TYPE_ACCEL_IR, 12, FILL_ONES);
      send_report(TYPE_ACCEL_IR, 12, FILL_RANDOM);
      send_report(TYPE_BUTTONS_ACC, 12, FILL_ONES);
      send_report(TYPE_BUTTONS, 3, FILL_ONES);
      send_report(TYPE_STATUS, 7, FILL_ONES);
      send_report(TYPE_STATUS, 7, FILL_ZERO);
      send_report(TYPE_READ_DATA, REPORT_BYTES, FILL_ONES);
      send_report(TYPE_WRITE_ACK, 12, FILL_ZERO);
      send_report(8'hff, 12, FILL_ZERO);
      send_report(8'h00, 1, FILL_ZERO);
      send_report(TYPE_ACCEL_IR, 7, FILL_RANDOM);
      send_report(TYPE_ACCEL_IR, 10, FILL_RANDOM);
      send_report(TYPE_ACCEL_IR, REPORT_BYTES + 8, FILL_RANDOM);

      for (int unsigned phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 58; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 58; end
            default: begin idle_pct = 6; stall_pct = 6; end
         endcase
         bytes_sent = 0;
         while (bytes_sent < BYTES_PER_PHASE) send_random_report();
      end

      req_push <= 1'b0;
      while (sb.expected_snapshots.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
